>>> rtl/tkpq_pkg.sv
// ----------------------------------------------------------------------------
// tkpq_pkg: types and constants for the three-key priority queue
// Holds the item types of both channels and the default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkpq_pkg;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefStampBits = 16;

  localparam logic ActInsert = 1'b0;
  localparam logic ActPop    = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] entry_tag;
    logic [2:0] class_level;
    logic [7:0] severity;
  } tkpq_in_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_tag;
    logic [2:0]  out_class;
    logic [7:0]  out_severity;
    logic [15:0] out_stamp;
    logic        overflow;
    logic [4:0]  occupancy;
  } tkpq_out_t;

endpackage

>>> rtl/three_key_priority_queue_core.sv
// ----------------------------------------------------------------------------
// three_key_priority_queue_core: bounded three-key priority queue
// Entries live in a synchronous memory; a pop scans it for the best entry.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload     Handshake
// in       input      tkpq_in_t   in_valid_i / in_stall_o
// out      output     tkpq_out_t  out_valid_o / out_stall_i
//
// For an insert the free slot comes from the valid flops at once.
// For a pop the entry memory has one read port and is
// read one slot per cycle, with the best candidate kept in registers.
// Reset clears the valid flops, the counters and the control state at once.
// The next item is taken while a result waits in the output register; the
// block holds its next result until the waiting one has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_key_priority_queue_core
  import tkpq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned STAMP_BITS = DefStampBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tkpq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tkpq_out_t out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [7:0]            tag;
    logic [2:0]            cls;
    logic [7:0]            sev;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle, StScan, StLast, StResult
  } state_e;

  entry_t entry_mem [CAPACITY];
  entry_t rd_data_q;

  state_e                state_q;
  logic [CAPACITY-1:0]   valid_q;
  logic [STAMP_BITS-1:0] counter_q;
  logic [CntW-1:0]       count_q;
  logic [IdxW-1:0]       rd_idx_q, prev_idx_q, best_idx_q;
  logic                  prev_live_q, found_q;
  entry_t                best_q;
  tkpq_out_t             res_q;
  logic                  res_pend_q;
  logic                  out_valid_q;
  tkpq_out_t             out_data_q;

  // Lowest free slot.
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // Result of an insert, decided when the item is taken.
  tkpq_out_t ins_res;
  always_comb begin
    ins_res           = '0;
    ins_res.overflow  = !free_found;
    ins_res.occupancy = free_found ? 5'(count_q + 1'b1) : 5'(count_q);
  end

  // Strictly better: a later slot replaces only on a strict win.
  logic better;
  always_comb begin
    if (rd_data_q.cls != best_q.cls) begin
      better = rd_data_q.cls < best_q.cls;
    end else if (rd_data_q.sev != best_q.sev) begin
      better = rd_data_q.sev > best_q.sev;
    end else begin
      better = rd_data_q.stamp < best_q.stamp;
    end
  end

  logic accept_in;
  logic out_load;
  assign in_stall_o  = (state_q != StIdle);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == StResult) && res_pend_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  logic do_write;
  logic [IdxW-1:0] wr_idx;
  entry_t wr_data;
  assign do_write = accept_in && (in_data_i.action == ActInsert) && free_found;
  assign wr_idx   = free_idx;
  assign wr_data  = '{tag: in_data_i.entry_tag, cls: in_data_i.class_level,
                      sev: in_data_i.severity, stamp: counter_q};

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      entry_mem[wr_idx] <= wr_data;
    end
    rd_data_q <= entry_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      counter_q   <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      prev_idx_q  <= '0;
      best_idx_q  <= '0;
      prev_live_q <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      res_q       <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept_in) begin
            if (in_data_i.action == ActInsert) begin
              res_q <= ins_res;
              if (free_found) begin
                valid_q[free_idx] <= 1'b1;
                if (counter_q != '1) begin
                  counter_q <= counter_q + 1'b1;
                end
                count_q <= count_q + 1'b1;
              end
              state_q <= StResult;
            end else begin
              res_q       <= '0;
              rd_idx_q    <= '0;
              prev_live_q <= 1'b0;
              found_q     <= 1'b0;
              state_q     <= StScan;
            end
          end
        end
        StScan, StLast: begin
          // rd_data_q holds the slot addressed in the previous cycle.
          if (prev_live_q && valid_q[prev_idx_q] && (!found_q || better)) begin
            best_q     <= rd_data_q;
            best_idx_q <= prev_idx_q;
            found_q    <= 1'b1;
          end
          prev_idx_q  <= rd_idx_q;
          prev_live_q <= (state_q == StScan);
          if (state_q == StScan) begin
            if (rd_idx_q == IdxW'(CAPACITY - 1)) begin
              state_q <= StLast;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end else begin
            state_q <= StResult;
          end
        end
        StResult: begin
          if (!res_pend_q && found_q && !prev_live_q) begin
            valid_q[best_idx_q]  <= 1'b0;
            count_q              <= count_q - 1'b1;
            res_q.out_valid      <= 1'b1;
            res_q.out_tag        <= best_q.tag;
            res_q.out_class      <= best_q.cls;
            res_q.out_severity   <= best_q.sev;
            res_q.out_stamp      <= 16'(best_q.stamp);
            res_q.occupancy      <= 5'(count_q - 1'b1);
            found_q              <= 1'b0;
            res_pend_q           <= 1'b1;
          end else if (!res_pend_q && !prev_live_q) begin
            res_q.occupancy <= 5'(count_q);
            res_pend_q      <= 1'b1;
          end else if (out_load) begin
            res_pend_q <= 1'b0;
            state_q    <= StIdle;
          end
          prev_live_q <= 1'b0;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
